// ----- rtl/oasd_pkg.sv -----
// Shared types, constants and register map for the orientation and shake detector.
// Used by every module of the block; depends on nothing else.
package oasd_pkg;

  localparam int unsigned ACCEL_WIDTH_DEF = 16;
  localparam int unsigned TIME_WIDTH_DEF  = 48;

  // Work queue between the classifier front end and the state back end.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  localparam logic [14:0] ENTER_RST    = 15'd1536;
  localparam logic [14:0] RELEASE_RST  = 15'd1024;
  localparam logic [3:0]  REQUIRED_RST = 4'd4;
  localparam logic [15:0] JERK_RST     = 16'd3072;
  localparam logic [14:0] GRAV_NOM_RST = 15'd2511;
  localparam logic [14:0] GRAV_ERR_RST = 15'd1152;
  localparam logic [25:0] COOLDOWN_RST = 26'd2000000;

  typedef enum logic [2:0] {
    REG_ENTER    = 3'd0,
    REG_RELEASE  = 3'd1,
    REG_REQUIRED = 3'd2,
    REG_JERK     = 3'd3,
    REG_GRAV_NOM = 3'd4,
    REG_GRAV_ERR = 3'd5,
    REG_COOLDOWN = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [14:0] enter_thr;
    logic [14:0] release_thr;
    logic [3:0]  required;
    logic [15:0] jerk_thr;
    logic [14:0] grav_nom;
    logic [14:0] grav_err;
    logic [25:0] cooldown;
  } cfg_t;

  // Per-sample classification handed from the front end to the back end.
  typedef struct packed {
    logic shake_cand;     // jerk and gravity band both say shake
    logic want_left;      // Y below -enter threshold
    logic want_right;     // Y above +enter threshold
    logic below_release;  // |Y| below release threshold
  } cls_t;

  localparam int unsigned CLS_W = $bits(cls_t);

endpackage

// ----- rtl/oasd_front.sv -----
// Front end: accepts samples, keeps the previous sample, computes jerk and
// the squared-magnitude gravity band test, and pushes a classification word.
// Depends on oasd_pkg.
module oasd_front #(
  parameter int unsigned ACCEL_WIDTH = oasd_pkg::ACCEL_WIDTH_DEF,
  parameter int unsigned TIME_WIDTH  = oasd_pkg::TIME_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [ACCEL_WIDTH-1:0]     accel_x_i,
  input  logic signed [ACCEL_WIDTH-1:0]     accel_y_i,
  input  logic signed [ACCEL_WIDTH-1:0]     accel_z_i,
  input  logic [TIME_WIDTH-1:0]             time_us_i,
  input  oasd_pkg::cfg_t                    cfg_i,
  input  logic [oasd_pkg::QCNT_W-1:0]       q_count_i,
  output logic                              push_o,
  output oasd_pkg::cls_t                    push_cls_o,
  output logic [TIME_WIDTH-1:0]             push_time_o
);

  localparam int unsigned AW = ACCEL_WIDTH;
  localparam int unsigned JW = (AW + 3 > 16) ? AW + 3 : 16;
  localparam int unsigned MW = (2 * AW + 2 > 32) ? 2 * AW + 2 : 32;
  localparam int unsigned CW = ((AW > 16) ? AW : 16) + 1;
  localparam int unsigned CNT_SUM_W = oasd_pkg::QCNT_W + 1;

  logic accept;

  logic signed [AW-1:0] prev_x_q, prev_y_q, prev_z_q;
  logic                 have_prev_q;

  logic signed [AW:0] dx, dy, dz;
  logic [AW:0]        adx, ady, adz;
  logic [AW-1:0]      ax, ay, az;
  logic [2*AW-1:0]    sqx, sqy, sqz;
  logic [15:0]        hi;
  logic [14:0]        lo;
  logic [31:0]        hi2;
  logic [29:0]        lo2;
  logic signed [CW-1:0] y_ext, enter_ext;
  logic [CW-1:0]      ay_ext, release_ext;

  logic               s1_v_q;
  logic [AW:0]        s1_adx_q, s1_ady_q, s1_adz_q;
  logic [2*AW-1:0]    s1_sqx_q, s1_sqy_q, s1_sqz_q;
  logic [31:0]        s1_hi2_q;
  logic [29:0]        s1_lo2_q;
  logic               s1_lo_en_q;
  logic               s1_lt_q, s1_gt_q, s1_below_q, s1_have_prev_q;
  logic [TIME_WIDTH-1:0] s1_time_q;

  logic [JW-1:0]      jerk;
  logic [MW-1:0]      mag2;
  logic               outside;

  // Credit check: the queue must hold everything already in flight.
  assign in_ready_o = (CNT_SUM_W'(q_count_i) + CNT_SUM_W'(s1_v_q)) <
                      CNT_SUM_W'(oasd_pkg::QDEPTH);
  assign accept = in_valid_i & in_ready_o;

  always_comb begin
    dx  = {accel_x_i[AW-1], accel_x_i} - {prev_x_q[AW-1], prev_x_q};
    dy  = {accel_y_i[AW-1], accel_y_i} - {prev_y_q[AW-1], prev_y_q};
    dz  = {accel_z_i[AW-1], accel_z_i} - {prev_z_q[AW-1], prev_z_q};
    adx = dx[AW] ? (AW+1)'(-dx) : (AW+1)'(dx);
    ady = dy[AW] ? (AW+1)'(-dy) : (AW+1)'(dy);
    adz = dz[AW] ? (AW+1)'(-dz) : (AW+1)'(dz);
    ax  = accel_x_i[AW-1] ? AW'(-accel_x_i) : AW'(accel_x_i);
    ay  = accel_y_i[AW-1] ? AW'(-accel_y_i) : AW'(accel_y_i);
    az  = accel_z_i[AW-1] ? AW'(-accel_z_i) : AW'(accel_z_i);
    sqx = ax * ax;
    sqy = ay * ay;
    sqz = az * az;
    hi  = {1'b0, cfg_i.grav_nom} + {1'b0, cfg_i.grav_err};
    lo  = cfg_i.grav_nom - cfg_i.grav_err;
    hi2 = hi * hi;
    lo2 = lo * lo;
    y_ext       = CW'(accel_y_i);
    enter_ext   = signed'({(CW-15)'(0), cfg_i.enter_thr});
    ay_ext      = {(CW-AW)'(0), ay};
    release_ext = {(CW-15)'(0), cfg_i.release_thr};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      have_prev_q <= 1'b0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      prev_z_q    <= '0;
    end else begin
      s1_v_q <= accept;
      if (accept) begin
        have_prev_q <= 1'b1;
        prev_x_q    <= accel_x_i;
        prev_y_q    <= accel_y_i;
        prev_z_q    <= accel_z_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_adx_q       <= adx;
      s1_ady_q       <= ady;
      s1_adz_q       <= adz;
      s1_sqx_q       <= sqx;
      s1_sqy_q       <= sqy;
      s1_sqz_q       <= sqz;
      s1_hi2_q       <= hi2;
      s1_lo2_q       <= lo2;
      s1_lo_en_q     <= cfg_i.grav_err < cfg_i.grav_nom;
      s1_lt_q        <= y_ext < -enter_ext;
      s1_gt_q        <= y_ext > enter_ext;
      s1_below_q     <= ay_ext < release_ext;
      s1_have_prev_q <= have_prev_q;
      s1_time_q      <= time_us_i;
    end
  end

  always_comb begin
    jerk    = JW'(s1_adx_q) + JW'(s1_ady_q) + JW'(s1_adz_q);
    mag2    = MW'(s1_sqx_q) + MW'(s1_sqy_q) + MW'(s1_sqz_q);
    outside = (mag2 > MW'(s1_hi2_q)) || (s1_lo_en_q && (mag2 < MW'(s1_lo2_q)));
    push_cls_o.shake_cand    = s1_have_prev_q && (jerk > JW'(cfg_i.jerk_thr)) && outside;
    push_cls_o.want_left     = s1_lt_q;
    push_cls_o.want_right    = s1_gt_q;
    push_cls_o.below_release = s1_below_q;
  end

  assign push_o      = s1_v_q;
  assign push_time_o = s1_time_q;

endmodule

// ----- rtl/oasd_queue.sv -----
// Short FIFO of classification words between the front end and the back end.
// Depends on oasd_pkg for depth and pointer widths.
module oasd_queue #(
  parameter int unsigned WORD_W = oasd_pkg::CLS_W + oasd_pkg::TIME_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic [WORD_W-1:0]           data_i,
  input  logic                        pop_i,
  output logic [WORD_W-1:0]           data_o,
  output logic [oasd_pkg::QCNT_W-1:0] count_o
);

  logic [WORD_W-1:0]           entry_q [oasd_pkg::QDEPTH];
  logic [oasd_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [oasd_pkg::QCNT_W-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= data_i;
  end

  assign data_o  = entry_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

// ----- rtl/oasd_back.sv -----
// Back end: applies the shake cooldown and the landscape confirmation logic
// to queued classification words and holds the result word. Depends on oasd_pkg.
module oasd_back #(
  parameter int unsigned TIME_WIDTH = oasd_pkg::TIME_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  oasd_pkg::cfg_t              cfg_i,
  input  logic [oasd_pkg::QCNT_W-1:0] q_count_i,
  input  oasd_pkg::cls_t              head_cls_i,
  input  logic [TIME_WIDTH-1:0]       head_time_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        shake_o,
  output logic                        changed_o,
  output logic                        rotation_o
);

  logic                  last_valid_unused;
  logic [TIME_WIDTH-1:0] last_shake_q, elapsed;
  logic                  cur_q, cur_d, pend_q, pend_d;
  logic [3:0]            cnt_q, cnt_d, cnt_inc;
  logic                  wanted, shaken, changed;
  logic                  out_v_q, shake_q, changed_q;
  logic                  fire;

  assign last_valid_unused = 1'b0;
  assign fire    = (q_count_i != '0) && (!out_v_q || out_ready_i);
  assign pop_o   = fire;
  assign elapsed = head_time_i - last_shake_q;
  assign shaken  = head_cls_i.shake_cand &&
                   (elapsed > TIME_WIDTH'(cfg_i.cooldown)) && !last_valid_unused;

  always_comb begin
    cur_d   = cur_q;
    pend_d  = pend_q;
    cnt_d   = cnt_q;
    changed = 1'b0;
    cnt_inc = cnt_q + 4'd1;
    wanted  = cur_q;
    if (head_cls_i.want_left) begin
      wanted = 1'b0;
    end else if (head_cls_i.want_right) begin
      wanted = 1'b1;
    end
    if (shaken) begin
      pend_d = cur_q;
      cnt_d  = '0;
    end else if (head_cls_i.below_release || wanted == cur_q) begin
      pend_d = cur_q;
      cnt_d  = '0;
    end else if (wanted != pend_q) begin
      pend_d = wanted;
      cnt_d  = 4'd1;
    end else begin
      cnt_d = cnt_inc;
      if (cnt_inc >= cfg_i.required) begin
        changed = cur_q != pend_q;
        cur_d   = pend_q;
        cnt_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_shake_q <= '0;
      cur_q        <= 1'b0;
      pend_q       <= 1'b0;
      cnt_q        <= '0;
      out_v_q      <= 1'b0;
      shake_q      <= 1'b0;
      changed_q    <= 1'b0;
    end else if (fire) begin
      if (shaken) last_shake_q <= head_time_i;
      cur_q     <= cur_d;
      pend_q    <= pend_d;
      cnt_q     <= cnt_d;
      out_v_q   <= 1'b1;
      shake_q   <= shaken;
      changed_q <= changed;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  assign out_valid_o = out_v_q;
  assign shake_o     = shake_q;
  assign changed_o   = changed_q;
  assign rotation_o  = cur_q;

endmodule

// ----- rtl/accel_orientation_shake_detector_core.sv -----
// Orientation and shake detector top level: APB register file, front end,
// work queue and back end. Depends on oasd_pkg, oasd_front, oasd_queue, oasd_back.
// Path from the edge that accepts a sample word to result word valid: classify
// register at that edge, then queue write, then result register.
// Throughput: one word per cycle while the result side does not stall, set by the
// back end state update that retires one queue entry a cycle when it may fire.
// Reset: asynchronous active low; registers return to their defaults.
module accel_orientation_shake_detector_core #(
  parameter int unsigned ACCEL_WIDTH = oasd_pkg::ACCEL_WIDTH_DEF,
  parameter int unsigned TIME_WIDTH  = oasd_pkg::TIME_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // APB configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [oasd_pkg::ADDR_W-1:0]   paddr,
  input  logic [oasd_pkg::DATA_W-1:0]   pwdata,
  output logic [oasd_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  // Sample channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [ACCEL_WIDTH-1:0] accel_x_i,
  input  logic signed [ACCEL_WIDTH-1:0] accel_y_i,
  input  logic signed [ACCEL_WIDTH-1:0] accel_z_i,
  input  logic [TIME_WIDTH-1:0]         time_us_i,
  // Result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          shake_detected_o,
  output logic                          rotation_changed_o,
  output logic                          rotation_o
);

  localparam int unsigned WORD_W = oasd_pkg::CLS_W + TIME_WIDTH;

  oasd_pkg::cfg_t              cfg_q;
  oasd_pkg::reg_idx_e          reg_idx;
  logic                        cfg_wr;

  logic                        q_push, q_pop;
  oasd_pkg::cls_t              push_cls, head_cls;
  logic [TIME_WIDTH-1:0]       push_time, head_time;
  logic [WORD_W-1:0]           head_word;
  logic [oasd_pkg::QCNT_W-1:0] q_count;

  // ---------------------------------------------------------------------
  // Register file. Writes land on the access phase; reads are zero-extended.
  // ---------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = oasd_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enter_thr   <= oasd_pkg::ENTER_RST;
      cfg_q.release_thr <= oasd_pkg::RELEASE_RST;
      cfg_q.required    <= oasd_pkg::REQUIRED_RST;
      cfg_q.jerk_thr    <= oasd_pkg::JERK_RST;
      cfg_q.grav_nom    <= oasd_pkg::GRAV_NOM_RST;
      cfg_q.grav_err    <= oasd_pkg::GRAV_ERR_RST;
      cfg_q.cooldown    <= oasd_pkg::COOLDOWN_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        oasd_pkg::REG_ENTER:    cfg_q.enter_thr   <= pwdata[14:0];
        oasd_pkg::REG_RELEASE:  cfg_q.release_thr <= pwdata[14:0];
        oasd_pkg::REG_REQUIRED: cfg_q.required    <= pwdata[3:0];
        oasd_pkg::REG_JERK:     cfg_q.jerk_thr    <= pwdata[15:0];
        oasd_pkg::REG_GRAV_NOM: cfg_q.grav_nom    <= pwdata[14:0];
        oasd_pkg::REG_GRAV_ERR: cfg_q.grav_err    <= pwdata[14:0];
        oasd_pkg::REG_COOLDOWN: cfg_q.cooldown    <= pwdata[25:0];
        default: ;  // hole in the map: drop the write
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      oasd_pkg::REG_ENTER:    prdata = {17'd0, cfg_q.enter_thr};
      oasd_pkg::REG_RELEASE:  prdata = {17'd0, cfg_q.release_thr};
      oasd_pkg::REG_REQUIRED: prdata = {28'd0, cfg_q.required};
      oasd_pkg::REG_JERK:     prdata = {16'd0, cfg_q.jerk_thr};
      oasd_pkg::REG_GRAV_NOM: prdata = {17'd0, cfg_q.grav_nom};
      oasd_pkg::REG_GRAV_ERR: prdata = {17'd0, cfg_q.grav_err};
      oasd_pkg::REG_COOLDOWN: prdata = {6'd0, cfg_q.cooldown};
      default:                prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Front end: classify each sample; it only takes a word when the queue
  // has room for it plus the one in its register stage.
  // ---------------------------------------------------------------------
  oasd_front #(
    .ACCEL_WIDTH (ACCEL_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .accel_x_i   (accel_x_i),
    .accel_y_i   (accel_y_i),
    .accel_z_i   (accel_z_i),
    .time_us_i   (time_us_i),
    .cfg_i       (cfg_q),
    .q_count_i   (q_count),
    .push_o      (q_push),
    .push_cls_o  (push_cls),
    .push_time_o (push_time)
  );

  // Decouple classification from the stateful back end.
  oasd_queue #(
    .WORD_W (WORD_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  ({push_cls, push_time}),
    .pop_i   (q_pop),
    .data_o  (head_word),
    .count_o (q_count)
  );

  assign head_cls  = oasd_pkg::cls_t'(head_word[WORD_W-1:TIME_WIDTH]);
  assign head_time = head_word[TIME_WIDTH-1:0];

  // Back end: cooldown, hysteresis and confirmation; holds the result word
  // while the consumer stalls.
  oasd_back #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_count_i   (q_count),
    .head_cls_i  (head_cls),
    .head_time_i (head_time),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .shake_o     (shake_detected_o),
    .changed_o   (rotation_changed_o),
    .rotation_o  (rotation_o)
  );

`ifndef ASSERT_OFF
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= oasd_pkg::QCNT_W'(oasd_pkg::QDEPTH))
    else $error("work queue over its depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> (q_count != '0))
    else $error("back end retired from an empty queue");

  a_shake_no_rotate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(shake_detected_o && rotation_changed_o))
    else $error("shake word also commits a rotation");

  a_no_push_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_count == oasd_pkg::QCNT_W'(oasd_pkg::QDEPTH)) |-> (!q_push || q_pop))
    else $error("push into a full work queue");
`endif

endmodule

// ----- tb/tb.sv -----
// Self-checking bench for accel_orientation_shake_detector_core: APB setup,
// randomized sample stream, in-bench predictor and in-order result checker.
// Depends on oasd_pkg and the core RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import oasd_pkg::*;

  localparam int unsigned ACCEL_W = ACCEL_WIDTH_DEF;
  localparam int unsigned TIME_W  = TIME_WIDTH_DEF;
  // Sample word in to result word out.
  localparam int LATENCY = 2;
  // Cycles without any handshake before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int REPORT_LIMIT = 10;

  // Landscape sides as the core encodes them.
  localparam logic ROT_LEFT  = 1'b0;
  localparam logic ROT_RIGHT = 1'b1;

  typedef struct packed {
    logic signed [ACCEL_W-1:0] x;
    logic signed [ACCEL_W-1:0] y;
    logic signed [ACCEL_W-1:0] z;
    logic [TIME_W-1:0]         stamp;
  } sample_t;

  typedef struct packed {
    logic shake;
    logic changed;
    logic rotation;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                      psel, penable, pwrite;
  logic [ADDR_W-1:0]         paddr;
  logic [DATA_W-1:0]         pwdata;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;

  logic                      in_valid_i;
  logic                      in_ready_o;
  logic signed [ACCEL_W-1:0] accel_x_i, accel_y_i, accel_z_i;
  logic [TIME_W-1:0]         time_us_i;

  logic                      out_valid_o;
  logic                      out_ready_i;
  logic                      shake_detected_o, rotation_changed_o, rotation_o;

  accel_orientation_shake_detector_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .accel_x_i          (accel_x_i),
    .accel_y_i          (accel_y_i),
    .accel_z_i          (accel_z_i),
    .time_us_i          (time_us_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .shake_detected_o   (shake_detected_o),
    .rotation_changed_o (rotation_changed_o),
    .rotation_o         (rotation_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: mirror of the detector state and its register copy.
  // ---------------------------------------------------------------------------
  cfg_t                      dev_cfg;
  logic signed [ACCEL_W-1:0] last_x, last_y, last_z;
  logic                      seen_any;
  logic [TIME_W-1:0]         prev_shake_stamp;
  logic                      cur_rot, pend_rot;
  logic [3:0]                confirm_cnt;

  sample_t  sample_queue[$];       // words waiting to be offered
  verdict_t expected_verdicts[$];  // predictions waiting for their result word

  int  sender_idle_pct;
  int  receiver_idle_pct;
  int  hold_cycles;
  bit  sample_taken;
  int  fault_count;
  int  quiet_cycles;
  logic [TIME_W-1:0] stamp;

  // Advance the detector state by one sample and return the result it owes.
  function automatic verdict_t classify_sample(input logic signed [ACCEL_W-1:0] ax,
                                               input logic signed [ACCEL_W-1:0] ay,
                                               input logic signed [ACCEL_W-1:0] az,
                                               input logic [TIME_W-1:0] now);
    longint x, y, z, px, py, pz;
    longint jerk, mag2, nom, err, hi, lo, enter, rel, jthr, ymag;
    logic [TIME_W-1:0] since;
    logic outside, wanted;
    verdict_t v;
    x = longint'(ax); y = longint'(ay); z = longint'(az);
    px = longint'(last_x); py = longint'(last_y); pz = longint'(last_z);
    nom = longint'(dev_cfg.grav_nom);
    err = longint'(dev_cfg.grav_err);
    enter = longint'(dev_cfg.enter_thr);
    rel = longint'(dev_cfg.release_thr);
    jthr = longint'(dev_cfg.jerk_thr);

    jerk = (x >= px ? x - px : px - x) + (y >= py ? y - py : py - y)
         + (z >= pz ? z - pz : pz - z);
    mag2 = x * x + y * y + z * z;
    hi = nom + err;
    outside = mag2 > hi * hi;
    // Lower edge of the gravity band only exists while it stays positive.
    if (err < nom) begin
      lo = nom - err;
      if (mag2 < lo * lo) outside = 1'b1;
    end
    since = now - prev_shake_stamp;

    v.shake = seen_any && (jerk > jthr) && outside && (since > TIME_W'(dev_cfg.cooldown));
    v.changed = 1'b0;

    last_x = ax; last_y = ay; last_z = az;
    seen_any = 1'b1;

    if (v.shake) begin
      prev_shake_stamp = now;
      pend_rot = cur_rot;
      confirm_cnt = '0;
    end else begin
      wanted = cur_rot;
      if (y < -enter) wanted = ROT_LEFT;
      else if (y > enter) wanted = ROT_RIGHT;
      ymag = y < 0 ? -y : y;
      if (ymag < rel || wanted == cur_rot) begin
        pend_rot = cur_rot;
        confirm_cnt = '0;
      end else if (wanted != pend_rot) begin
        pend_rot = wanted;
        confirm_cnt = 4'd1;
      end else begin
        confirm_cnt = confirm_cnt + 4'd1;
        if (confirm_cnt >= dev_cfg.required) begin
          v.changed = cur_rot != pend_rot;
          cur_rot = pend_rot;
          confirm_cnt = '0;
        end
      end
    end
    v.rotation = cur_rot;
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Sample driver: present a new word at the falling edge once the last one
  // went through, hold it otherwise.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      expected_verdicts.push_back(classify_sample(accel_x_i, accel_y_i, accel_z_i,
                                                  time_us_i));
      sample_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    sample_t s;
    if (!in_valid_i || sample_taken) begin
      sample_taken = 1'b0;
      if (sample_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        s = sample_queue.pop_front();
        in_valid_i <= 1'b1;
        accel_x_i  <= s.x;
        accel_y_i  <= s.y;
        accel_z_i  <= s.z;
        time_us_i  <= s.stamp;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result side backpressure; a pending hold-off wins over the random pattern.
  always @(negedge clk_i) begin
    if (hold_cycles != 0) begin
      hold_cycles = hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= $urandom_range(0, 99) >= receiver_idle_pct;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare every result word against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_verdicts.size() == 0) begin
        fault_count = fault_count + 1;
        if (fault_count <= REPORT_LIMIT)
          $display("%0t: result word with nothing expected (shake=%0b chg=%0b rot=%0b)",
                   $realtime, shake_detected_o, rotation_changed_o, rotation_o);
      end else begin
        want = expected_verdicts.pop_front();
        if (want.shake !== shake_detected_o || want.changed !== rotation_changed_o ||
            want.rotation !== rotation_o) begin
          fault_count = fault_count + 1;
          if (fault_count <= REPORT_LIMIT)
            $display("%0t: mismatch exp shake=%0b chg=%0b rot=%0b, %s",
                     $realtime, want.shake, want.changed, want.rotation,
                     $sformatf("got shake=%0b chg=%0b rot=%0b",
                               shake_detected_o, rotation_changed_o, rotation_o));
        end
      end
    end
  end

  // Hang detector: a sample or result handshake, or an APB write, counts as progress.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable && pwrite && pready))
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration and stimulus helpers
  // ---------------------------------------------------------------------------
  // APB write: setup cycle, then access cycle; mirror the register on completion.
  task automatic write_reg(input reg_idx_e idx, input logic [DATA_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ENTER:    dev_cfg.enter_thr   = value[14:0];
      REG_RELEASE:  dev_cfg.release_thr = value[14:0];
      REG_REQUIRED: dev_cfg.required    = value[3:0];
      REG_JERK:     dev_cfg.jerk_thr    = value[15:0];
      REG_GRAV_NOM: dev_cfg.grav_nom    = value[14:0];
      REG_GRAV_ERR: dev_cfg.grav_err    = value[14:0];
      REG_COOLDOWN: dev_cfg.cooldown    = value[25:0];
      default: ;
    endcase
  endtask

  task automatic program_thresholds(input int enter, input int rel, input int req,
                                    input int jerk, input int nom, input int err,
                                    input int cool);
    write_reg(REG_ENTER, enter);
    write_reg(REG_RELEASE, rel);
    write_reg(REG_REQUIRED, req);
    write_reg(REG_JERK, jerk);
    write_reg(REG_GRAV_NOM, nom);
    write_reg(REG_GRAV_ERR, err);
    write_reg(REG_COOLDOWN, cool);
  endtask

  function automatic logic signed [ACCEL_W-1:0] clip_axis(input longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return {1'b1, {(ACCEL_W-1){1'b0}}};
    return v[ACCEL_W-1:0];
  endfunction

  task automatic add_sample(input longint x, input longint y, input longint z,
                            input logic [TIME_W-1:0] t);
    sample_t s;
    s.x = clip_axis(x);
    s.y = clip_axis(y);
    s.z = clip_axis(z);
    s.stamp = t;
    sample_queue.push_back(s);
  endtask

  function automatic longint wobble(input int span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic longint any_axis();
    logic [31:0] r;
    logic signed [ACCEL_W-1:0] a;
    r = $urandom;
    a = r[ACCEL_W-1:0];
    return longint'(a);
  endfunction

  // Mostly tilt runs that walk the confirmation counter, mixed with
  // hysteresis-band and release samples, shakes and raw noise.
  task automatic queue_random(input int count);
    int made, pick, run, k, lo_y, hi_y;
    logic side;
    longint yv;
    logic [63:0] r;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        run = $urandom_range(1, dev_cfg.required + 3);
        side = 1'($urandom_range(0, 1));
        for (k = 0; k < run; k++) begin
          yv = longint'(dev_cfg.enter_thr) + longint'($urandom_range(1, 600));
          stamp = stamp + $urandom_range(1, 30000);
          add_sample(wobble(100), side ? yv : -yv, 1800 + wobble(150), stamp);
        end
        made = made + run;
      end else if (pick < 60) begin
        lo_y = dev_cfg.release_thr < dev_cfg.enter_thr ? int'(dev_cfg.release_thr)
                                                        : int'(dev_cfg.enter_thr);
        hi_y = dev_cfg.release_thr < dev_cfg.enter_thr ? int'(dev_cfg.enter_thr)
                                                        : int'(dev_cfg.release_thr);
        yv = longint'($urandom_range(lo_y, hi_y));
        stamp = stamp + $urandom_range(1, 30000);
        add_sample(wobble(100), $urandom_range(0, 1) ? yv : -yv, 1800 + wobble(150), stamp);
        made = made + 1;
      end else if (pick < 72) begin
        yv = longint'($urandom_range(0, dev_cfg.release_thr));
        stamp = stamp + $urandom_range(1, 30000);
        add_sample(wobble(300), $urandom_range(0, 1) ? yv : -yv, 2000 + wobble(300), stamp);
        made = made + 1;
      end else if (pick < 90) begin
        // Shake attempt: either past the cooldown or inside it.
        if ($urandom_range(0, 1))
          stamp = stamp + dev_cfg.cooldown + $urandom_range(1, 5000);
        else
          stamp = stamp + $urandom_range(0, 3000);
        if ($urandom_range(0, 3) == 0)
          add_sample(wobble(200), wobble(200), wobble(200), stamp);
        else
          add_sample(any_axis(), any_axis(), any_axis(), stamp);
        made = made + 1;
      end else begin
        r = {$urandom, $urandom};
        add_sample(any_axis(), any_axis(), any_axis(), r[TIME_W-1:0]);
        made = made + 1;
      end
    end
  endtask

  // Wait for every offered word to come back, then let the pipe run dry.
  task automatic settle();
    do @(posedge clk_i);
    while (sample_queue.size() != 0 || in_valid_i || expected_verdicts.size() != 0);
    repeat (LATENCY + 3) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int k;
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid_i  = 1'b0;
    out_ready_i = 1'b0;
    accel_x_i   = '0;
    accel_y_i   = '0;
    accel_z_i   = '0;
    time_us_i   = '0;
    sample_taken = 1'b0;
    hold_cycles  = 0;
    fault_count  = 0;
    quiet_cycles = 0;
    sender_idle_pct   = 36;
    receiver_idle_pct = 65;

    dev_cfg.enter_thr   = ENTER_RST;
    dev_cfg.release_thr = RELEASE_RST;
    dev_cfg.required    = REQUIRED_RST;
    dev_cfg.jerk_thr    = JERK_RST;
    dev_cfg.grav_nom    = GRAV_NOM_RST;
    dev_cfg.grav_err    = GRAV_ERR_RST;
    dev_cfg.cooldown    = COOLDOWN_RST;
    last_x = '0; last_y = '0; last_z = '0;
    seen_any = 1'b0;
    prev_shake_stamp = '0;
    cur_rot = ROT_LEFT;
    pend_rot = ROT_LEFT;
    confirm_cnt = '0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed, reset thresholds. First sample can never shake.
    add_sample(32767, -32768, -32768, 48'd3000000);
    // Cooldown counts from time zero: equal to the cooldown is still too early.
    add_sample(-32768, 32767, 32767, 48'd1000);
    add_sample(32767, 32767, -32768, 48'd2000000);
    add_sample(-32768, 32767, 32767, 48'd2000001);
    // Right side just above enter, confirmed on four samples, then exactly
    // at the enter level on both sides.
    stamp = 48'd2100000;
    for (k = 0; k < 4; k++) begin
      stamp = stamp + 1000;
      add_sample(0, 1537, 2000, stamp);
    end
    add_sample(0, 1536, 2000, stamp + 1);
    add_sample(0, -1536, 2000, stamp + 2);
    // Left proposal broken by the hysteresis band and by release.
    add_sample(0, -1537, 2000, stamp + 3);
    add_sample(0, -1200, 2000, stamp + 4);
    add_sample(0, -1537, 2000, stamp + 5);
    add_sample(0, -1537, 2000, stamp + 6);
    add_sample(0, -1023, 2000, stamp + 7);
    add_sample(0, -1024, 2000, stamp + 8);
    // Shake at full scale, then the same sample held commits the left side.
    stamp = 48'd5000000;
    for (k = 0; k < 5; k++) add_sample(0, -32768, 0, stamp + k);
    // Timestamp wrap across the top of the counter.
    add_sample(32767, 32767, 32767, {TIME_W{1'b1}});
    add_sample(-32768, -32768, -32768, 48'd4);
    add_sample(0, 0, 0, {TIME_W{1'b1}});
    stamp = 48'd6000000;
    queue_random(100);
    settle();

    // Swap idling: sender slow, receiver quick.
    sender_idle_pct   = 65;
    receiver_idle_pct = 36;
    program_thresholds(800, 300, 1, 1000, 2511, 0, 0);
    queue_random(100);
    settle();

    // All zero: any move is a shake, any repeat commits at once.
    program_thresholds(0, 0, 0, 0, 0, 0, 0);
    queue_random(60);
    settle();

    // No idling from here on.
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    program_thresholds(32767, 32767, 15, 65535, 32767, 32767, 67108863);
    queue_random(60);
    settle();

    // Error wider than nominal leaves only the upper band edge.
    program_thresholds(2000, 1500, 2, 4000, 1000, 3000, 50000);
    queue_random(100);
    // Stall the result side long enough to back the core up to its input.
    @(posedge clk_i);
    hold_cycles = 60;
    settle();

    if (fault_count == 0 && expected_verdicts.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/oasd_pkg.sv
rtl/oasd_front.sv
rtl/oasd_queue.sv
rtl/oasd_back.sv
rtl/accel_orientation_shake_detector_core.sv
tb/tb.sv
